// ===== design/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants
// Opcodes, event and message words, preset defaults for the control-surface
// to control-change converter.
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam int ANALOG_INPUTS = 13;
  localparam int PRESET_WORDS  = 32;
  localparam int PRESET_AW     = 5;
  localparam int PRESET_DW     = 7;
  localparam int MASK_BITS     = 13;

  typedef enum logic [1:0] {
    OP_ANALOG  = 2'd0,
    OP_ENCODER = 2'd1,
    OP_KEY     = 2'd2,
    OP_PRESET  = 2'd3
  } ccm_op_t;

  // configuration register indexes
  localparam logic REG_HYSTERESIS = 1'b0;
  localparam logic REG_INVERT     = 1'b1;

  // preset word of the encoder and the push key (channel half)
  localparam logic [3:0] ENC_WORD = 4'd13;
  localparam logic [3:0] KEY_WORD = 4'd14;

  // encoder pin states
  localparam logic [1:0] ENC_IDLE = 2'd3;
  localparam logic [1:0] ENC_DOWN = 2'd2;
  localparam logic [1:0] ENC_UP   = 2'd1;

  localparam logic [1:0] KEY_UNKNOWN = 2'd2;

  localparam logic [6:0] CC_MAX  = 7'h7F;
  localparam logic [6:0] CC_ZERO = 7'h00;

  localparam logic [9:0]  HYST_RESET   = 10'd7;
  localparam logic [12:0] INVERT_RESET = 13'h0E0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] control_index;
    logic [9:0] sample;
    logic [1:0] encoder_first;
    logic [1:0] encoder_second;
    logic       key_level;
    logic [4:0] preset_index;
    logic [7:0] preset_value;
  } ccm_item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] midi_channel;
    logic [6:0] controller_number;
    logic [6:0] cc_value;
  } ccm_msg_t;

  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [6:0] data;
  } ccm_pwr_t;

  typedef struct packed {
    logic [9:0]  hysteresis_threshold;
    logic [12:0] invert_mask;
  } ccm_cfg_t;

  // built-in preset words: channels 0, controllers 70..77, 1..7, 0
  function automatic logic [6:0] preset_default(input logic [4:0] addr);
    logic [6:0] word;
    case (addr) inside
      [5'd16:5'd23]: word = 7'd54 + {2'b00, addr};
      [5'd24:5'd30]: word = {2'b00, addr} - 7'd23;
      default:       word = 7'd0;
    endcase
    return word;
  endfunction

endpackage

// ===== design/ccm_event_if.sv =====
// ----------------------------------------------------------------------------
// ccm_event_if: control-surface event channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface ccm_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] control_index;
  logic [9:0] sample;
  logic [1:0] encoder_first;
  logic [1:0] encoder_second;
  logic       key_level;
  logic [4:0] preset_index;
  logic [7:0] preset_value;

  modport source (output valid, opcode, control_index, sample, encoder_first,
                  encoder_second, key_level, preset_index, preset_value,
                  input ready);
  modport sink (input valid, opcode, control_index, sample, encoder_first,
                encoder_second, key_level, preset_index, preset_value,
                output ready);
endinterface

// ===== design/ccm_msg_if.sv =====
// ----------------------------------------------------------------------------
// ccm_msg_if: control-change message channel
// Valid/ready channel carrying one message word.
// ----------------------------------------------------------------------------
interface ccm_msg_if;
  logic       valid;
  logic       ready;
  logic [3:0] midi_channel;
  logic [6:0] controller_number;
  logic [6:0] cc_value;

  modport source (output valid, midi_channel, controller_number, cc_value,
                  input ready);
  modport sink (input valid, midi_channel, controller_number, cc_value,
                output ready);
endinterface

// ===== design/ccm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ccm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ccm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/control_surface_to_midi_cc.sv =====
// ----------------------------------------------------------------------------
// control_surface_to_midi_cc: control-surface events to control-change words
// Analog knobs with hysteresis, encoder and push key, preset table lookup.
// ----------------------------------------------------------------------------
//  channel    direction  handshake      word
//  events     in         valid/ready    opcode, index, sample, pins, preset
//  messages   out        valid/ready    midi_channel, controller, cc_value
//  cfg        in         valid/ready    index (0 threshold, 1 mask), data
//
// one event word per cycle unless messages stall; an event passes the input
// register with preset read, then the decision into the output register
// synchronous reset restores thresholds, stored samples and preset defaults
// a stalled message holds the output register; the input register keeps
// taking words as long as the decision stage can move
// cfg is always ready
// ----------------------------------------------------------------------------
module control_surface_to_midi_cc #(
  parameter int ANALOG_INPUTS = ccm_pkg::ANALOG_INPUTS
) (
  input logic       clk,
  input logic       rst,
  ccm_event_if.sink events,
  ccm_msg_if.source messages,
  ccm_cfg_if.sink   cfg
);

  // stage one: registered event word, preset words read alongside
  logic               s1_valid;
  ccm_pkg::ccm_item_t s1_item;
  logic               fire;
  logic               accept;
  logic [3:0]         rd_src;

  // configuration registers
  ccm_pkg::ccm_cfg_t  cfg_regs;

  // decision outputs
  ccm_pkg::ccm_msg_t  res;
  ccm_pkg::ccm_pwr_t  pwr;
  logic [6:0]         chan_word;
  logic [6:0]         ctrl_word;

  // output register
  logic               out_valid;
  logic [3:0]         out_channel;
  logic [6:0]         out_controller;
  logic [6:0]         out_value;

  // decision stage moves when the output register is empty or draining
  assign fire         = s1_valid && (!out_valid || messages.ready);
  assign events.ready = !s1_valid || fire;
  assign accept       = events.valid && events.ready;
  assign cfg.ready    = 1'b1;

  // preset word source: knob number, or the fixed encoder / key words
  always_comb begin
    case (events.opcode)
      ccm_pkg::OP_ANALOG:  rd_src = events.control_index;
      ccm_pkg::OP_ENCODER: rd_src = ccm_pkg::ENC_WORD;
      default:             rd_src = ccm_pkg::KEY_WORD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (events.ready) begin
      s1_valid <= events.valid;
    end
    if (accept) begin
      s1_item.opcode         <= events.opcode;
      s1_item.control_index  <= events.control_index;
      s1_item.sample         <= events.sample;
      s1_item.encoder_first  <= events.encoder_first;
      s1_item.encoder_second <= events.encoder_second;
      s1_item.key_level      <= events.key_level;
      s1_item.preset_index   <= events.preset_index;
      s1_item.preset_value   <= events.preset_value;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.hysteresis_threshold <= ccm_pkg::HYST_RESET;
      cfg_regs.invert_mask          <= ccm_pkg::INVERT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ccm_pkg::REG_HYSTERESIS: cfg_regs.hysteresis_threshold <= cfg.data[9:0];
        ccm_pkg::REG_INVERT:     cfg_regs.invert_mask          <= cfg.data;
        default:                 cfg_regs <= cfg_regs;
      endcase
    end
  end

  ccm_preset u_preset (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_src    (rd_src),
    .wr        (pwr),
    .chan_word (chan_word),
    .ctrl_word (ctrl_word)
  );

  ccm_core #(
    .ANALOG_INPUTS (ANALOG_INPUTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .cfg       (cfg_regs),
    .chan_word (chan_word),
    .ctrl_word (ctrl_word),
    .res       (res),
    .pwr       (pwr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.valid;
    end else if (messages.ready) begin
      out_valid <= 1'b0;
    end
    if (fire && res.valid) begin
      out_channel    <= res.midi_channel;
      out_controller <= res.controller_number;
      out_value      <= res.cc_value;
    end
  end

  assign messages.valid             = out_valid;
  assign messages.midi_channel      = out_channel;
  assign messages.controller_number = out_controller;
  assign messages.cc_value          = out_value;

`ifndef SYNTHESIS
  // a preset write never yields a message
  a_preset_silent: assert property (@(posedge clk) disable iff (rst)
    fire && s1_item.opcode == ccm_pkg::OP_PRESET |=> !messages.valid)
    else $error("preset write produced a message");

  // a held event word stays put until the decision stage takes it
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_item))
    else $error("stage one word lost while stalled");

  // every decided message lands in the output register
  a_msg_loaded: assert property (@(posedge clk) disable iff (rst)
    fire && res.valid |=> messages.valid)
    else $error("decided message not presented");

  // preset writes only come from the decision stage
  a_pwr_fire: assert property (@(posedge clk) disable iff (rst)
    pwr.en |-> fire && !s1_item.preset_value[7])
    else $error("preset write outside a decision");
`endif

endmodule

// ===== design/ccm_ram.sv =====
// ----------------------------------------------------------------------------
// ccm_ram: generic ram
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/ccm_preset.sv =====
// ----------------------------------------------------------------------------
// ccm_preset: preset table
// Ram with per-word valid bits over the built-in defaults, write bypass.
// ----------------------------------------------------------------------------
module ccm_preset (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [3:0]        rd_src,
  input  ccm_pkg::ccm_pwr_t wr,
  output logic [6:0]        chan_word,
  output logic [6:0]        ctrl_word
);

  logic [ccm_pkg::PRESET_WORDS-1:0] written;
  logic [ccm_pkg::PRESET_AW-1:0]    addr_a;
  logic [ccm_pkg::PRESET_AW-1:0]    addr_b;
  logic [ccm_pkg::PRESET_DW-1:0]    ram_a;
  logic [ccm_pkg::PRESET_DW-1:0]    ram_b;
  logic                             use_ram_a;
  logic                             use_ram_b;
  logic [ccm_pkg::PRESET_DW-1:0]    hold_a;
  logic [ccm_pkg::PRESET_DW-1:0]    hold_b;
  logic                             hit_a;
  logic                             hit_b;

  assign addr_a = {1'b0, rd_src};
  assign addr_b = {1'b1, rd_src};
  assign hit_a  = wr.en && (wr.addr == addr_a);
  assign hit_b  = wr.en && (wr.addr == addr_b);

  ccm_ram #(
    .WIDTH (ccm_pkg::PRESET_DW),
    .DEPTH (ccm_pkg::PRESET_WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (rd_en),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // unwritten words read their default, a same-cycle write is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      use_ram_a <= written[addr_a] && !hit_a;
      use_ram_b <= written[addr_b] && !hit_b;
      hold_a    <= hit_a ? wr.data : ccm_pkg::preset_default(addr_a);
      hold_b    <= hit_b ? wr.data : ccm_pkg::preset_default(addr_b);
    end
  end

  assign chan_word = use_ram_a ? ram_a : hold_a;
  assign ctrl_word = use_ram_b ? ram_b : hold_b;

endmodule

// ===== design/ccm_core.sv =====
// ----------------------------------------------------------------------------
// ccm_core: event decision logic
// Hysteresis test, encoder and key state tracking, message and preset write.
// ----------------------------------------------------------------------------
module ccm_core #(
  parameter int ANALOG_INPUTS = ccm_pkg::ANALOG_INPUTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ccm_pkg::ccm_item_t item,
  input  ccm_pkg::ccm_cfg_t  cfg,
  input  logic [6:0]         chan_word,
  input  logic [6:0]         ctrl_word,
  output ccm_pkg::ccm_msg_t  res,
  output ccm_pkg::ccm_pwr_t  pwr
);

  localparam int IDX_W = (ANALOG_INPUTS > 1) ? $clog2(ANALOG_INPUTS) : 1;

  logic signed [10:0] last_sent [ANALOG_INPUTS];
  logic [1:0]         last_enc;
  logic [1:0]         last_key;

  logic [IDX_W-1:0]   slot;
  logic               in_range;
  logic signed [10:0] last_val;
  logic signed [11:0] diff;
  logic [11:0]        abs_diff;
  logic               analog_send;
  logic [12:0]        inv_bits;
  logic [6:0]         analog_val;
  logic               enc_change;
  logic               enc_send;
  logic [6:0]         enc_val;
  logic               key_change;
  logic [6:0]         key_val;

  assign slot       = item.control_index[IDX_W-1:0];
  assign in_range   = {1'b0, item.control_index} < 5'(ANALOG_INPUTS);
  assign last_val   = last_sent[slot];
  assign diff       = {last_val[10], last_val} - {2'b00, item.sample};
  assign abs_diff   = diff[11] ? 12'(-diff) : 12'(diff);
  assign analog_send = in_range && (abs_diff > {2'b00, cfg.hysteresis_threshold});
  // inputs past the mask width shift in zeros and never invert
  assign inv_bits   = cfg.invert_mask >> item.control_index;
  assign analog_val = item.sample[9:3] ^ {7{inv_bits[0]}};

  assign enc_change = (item.encoder_first == item.encoder_second) &&
                      (item.encoder_first != last_enc);
  assign enc_send   = enc_change && (last_enc == ccm_pkg::ENC_IDLE) &&
                      ((item.encoder_first == ccm_pkg::ENC_DOWN) ||
                       (item.encoder_first == ccm_pkg::ENC_UP));
  assign enc_val    = (item.encoder_first == ccm_pkg::ENC_UP) ? ccm_pkg::CC_MAX
                                                              : ccm_pkg::CC_ZERO;

  assign key_change = {1'b0, item.key_level} != last_key;
  assign key_val    = item.key_level ? ccm_pkg::CC_ZERO : ccm_pkg::CC_MAX;

  always_comb begin
    res.midi_channel      = chan_word[3:0];
    res.controller_number = ctrl_word;
    res.valid             = 1'b0;
    res.cc_value          = ccm_pkg::CC_ZERO;
    case (item.opcode)
      ccm_pkg::OP_ANALOG: begin
        res.valid    = analog_send;
        res.cc_value = analog_val;
      end
      ccm_pkg::OP_ENCODER: begin
        res.valid    = enc_send;
        res.cc_value = enc_val;
      end
      ccm_pkg::OP_KEY: begin
        res.valid    = key_change;
        res.cc_value = key_val;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  assign pwr.en   = fire && (item.opcode == ccm_pkg::OP_PRESET) && !item.preset_value[7];
  assign pwr.addr = item.preset_index;
  assign pwr.data = item.preset_value[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANALOG_INPUTS; i++) begin
        last_sent[i] <= '1;
      end
      last_enc <= ccm_pkg::ENC_IDLE;
      last_key <= ccm_pkg::KEY_UNKNOWN;
    end else if (fire) begin
      if (item.opcode == ccm_pkg::OP_ANALOG && analog_send) begin
        last_sent[slot] <= {1'b0, item.sample};
      end
      if (item.opcode == ccm_pkg::OP_ENCODER && enc_change) begin
        last_enc <= item.encoder_first;
      end
      if (item.opcode == ccm_pkg::OP_KEY && key_change) begin
        last_key <= {1'b0, item.key_level};
      end
    end
  end

endmodule

// ===== sim/cc_message_checker.sv =====
// ----------------------------------------------------------------------------
// cc_message_checker: control-change prediction and compare
// Watches the event, message and cfg channels, keeps its own copy of the
// converter state, and compares every accepted message with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module cc_message_checker (
  input  logic clk,
  input  logic rst,
  ccm_event_if events,
  ccm_msg_if   messages,
  ccm_cfg_if   cfg,
  output int   failures,
  output int   outstanding
);

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] controller;
    logic [6:0] value;
  } cc_word_t;

  logic [9:0]         thresh;
  logic [12:0]        invert;
  logic signed [10:0] last_sample [ccm_pkg::ANALOG_INPUTS];
  logic [6:0]         presets [ccm_pkg::PRESET_WORDS];
  logic [1:0]         enc_state;
  logic [1:0]         key_state;
  cc_word_t           expected_cc [$];

  task automatic load_defaults();
    thresh    = ccm_pkg::HYST_RESET;
    invert    = ccm_pkg::INVERT_RESET;
    enc_state = ccm_pkg::ENC_IDLE;
    key_state = ccm_pkg::KEY_UNKNOWN;
    for (int i = 0; i < ccm_pkg::ANALOG_INPUTS; i++) last_sample[i] = -11'sd1;
    // channels all 0, controllers 70..77 then 1..7 then 0
    for (int i = 0; i < ccm_pkg::PRESET_WORDS; i++) begin
      if (i >= 16 && i < 24) presets[i] = 7'(54 + i);
      else if (i >= 24 && i < 31) presets[i] = 7'(i - 23);
      else presets[i] = 7'd0;
    end
  endtask

  // source word src: channel from src, controller from src + 16
  function automatic cc_word_t lookup_cc(input logic [3:0] src, input logic [6:0] value);
    cc_word_t w;
    w.channel    = presets[{1'b0, src}][3:0];
    w.controller = presets[{1'b1, src}];
    w.value      = value;
    return w;
  endfunction

  task automatic predict_event(input ccm_pkg::ccm_item_t it);
    int         diff;
    logic [6:0] level;
    case (ccm_pkg::ccm_op_t'(it.opcode))
      ccm_pkg::OP_ANALOG: begin
        if (it.control_index < ccm_pkg::ANALOG_INPUTS) begin
          diff = int'(last_sample[it.control_index]) - int'(it.sample);
          if (diff > int'(thresh) || diff < -int'(thresh)) begin
            last_sample[it.control_index] = {1'b0, it.sample};
            level = it.sample[9:3];
            if (invert[it.control_index]) level = ~level;
            expected_cc.push_back(lookup_cc(it.control_index, level));
          end
        end
      end
      ccm_pkg::OP_ENCODER: begin
        if (it.encoder_first == it.encoder_second && it.encoder_first != enc_state) begin
          if (enc_state == ccm_pkg::ENC_IDLE && it.encoder_first == ccm_pkg::ENC_DOWN)
            expected_cc.push_back(lookup_cc(ccm_pkg::ENC_WORD, ccm_pkg::CC_ZERO));
          else if (enc_state == ccm_pkg::ENC_IDLE && it.encoder_first == ccm_pkg::ENC_UP)
            expected_cc.push_back(lookup_cc(ccm_pkg::ENC_WORD, ccm_pkg::CC_MAX));
          enc_state = it.encoder_first;
        end
      end
      ccm_pkg::OP_KEY: begin
        if ({1'b0, it.key_level} != key_state) begin
          key_state = {1'b0, it.key_level};
          expected_cc.push_back(lookup_cc(ccm_pkg::KEY_WORD,
                                          it.key_level ? ccm_pkg::CC_ZERO
                                                       : ccm_pkg::CC_MAX));
        end
      end
      default: begin
        if (!it.preset_value[7]) presets[it.preset_index] = it.preset_value[6:0];
      end
    endcase
  endtask

  function automatic void compare_field(input string field, input logic [6:0] want,
                                        input logic [6:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  task automatic check_message();
    cc_word_t want;
    if (expected_cc.size() == 0) begin
      failures++;
      $display("%0t: message expected none actual ch %0d cc %0d value %0d", $time,
               messages.midi_channel, messages.controller_number, messages.cc_value);
    end else begin
      want = expected_cc.pop_front();
      compare_field("midi_channel", {3'b000, want.channel}, {3'b000, messages.midi_channel});
      compare_field("controller_number", want.controller, messages.controller_number);
      compare_field("cc_value", want.value, messages.cc_value);
    end
  endtask

  // compare before predicting: a message leaving now belongs to an older event
  always @(posedge clk) begin
    if (rst) begin
      load_defaults();
      expected_cc.delete();
      failures = 0;
    end else begin
      if (messages.valid && messages.ready) check_message();
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == ccm_pkg::REG_HYSTERESIS) thresh = cfg.data[9:0];
        else invert = cfg.data;
      end
      if (events.valid && events.ready)
        predict_event({events.opcode, events.control_index, events.sample,
                       events.encoder_first, events.encoder_second, events.key_level,
                       events.preset_index, events.preset_value});
    end
    outstanding = expected_cc.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: control_surface_to_midi_cc top level
// Drives event words and register writes, stalls the message side at random,
// and leaves prediction and compare to cc_message_checker.
// ----------------------------------------------------------------------------
module testbench;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;

  // idling switches for the event sender and message receiver
  bit   tx_idle;
  bit   rx_idle;
  // asks the receiver for one long hold-off
  bit   squeeze;

  ccm_event_if ev ();
  ccm_msg_if   msg ();
  ccm_cfg_if   cf ();

  control_surface_to_midi_cc DUT (
    .clk      (clk),
    .rst      (rst),
    .events   (ev),
    .messages (msg),
    .cfg      (cf)
  );

  cc_message_checker monitor (
    .clk         (clk),
    .rst         (rst),
    .events      (ev),
    .messages    (msg),
    .cfg         (cf),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // 12-unit clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  // random event word; every field gets random bits, and the encoder reads
  // mostly agree and often come back to idle so the sends off idle are reached
  function automatic ccm_pkg::ccm_item_t random_event();
    ccm_pkg::ccm_item_t it;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) it.opcode = ccm_pkg::OP_ANALOG;
    else if (pick < 70) it.opcode = ccm_pkg::OP_ENCODER;
    else if (pick < 85) it.opcode = ccm_pkg::OP_KEY;
    else it.opcode = ccm_pkg::OP_PRESET;
    // now and then an index past the last knob
    if ($urandom_range(0, 9) == 0) it.control_index = 4'($urandom_range(13, 15));
    else it.control_index = 4'($urandom_range(0, 12));
    it.sample         = 10'($urandom);
    it.encoder_first  = ($urandom_range(0, 2) == 0) ? ccm_pkg::ENC_IDLE : 2'($urandom);
    it.encoder_second = ($urandom_range(0, 4) == 0) ? 2'($urandom) : it.encoder_first;
    it.key_level      = 1'($urandom);
    it.preset_index   = 5'($urandom);
    it.preset_value   = 8'($urandom);
    return it;
  endfunction

  // directed word builders; unused fields stay random
  function automatic ccm_pkg::ccm_item_t analog_event(input int idx, input int smp);
    ccm_pkg::ccm_item_t it;
    it = random_event();
    it.opcode        = ccm_pkg::OP_ANALOG;
    it.control_index = 4'(idx);
    it.sample        = 10'(smp);
    return it;
  endfunction

  function automatic ccm_pkg::ccm_item_t encoder_event(input logic [1:0] first,
                                                       input logic [1:0] second);
    ccm_pkg::ccm_item_t it;
    it = random_event();
    it.opcode         = ccm_pkg::OP_ENCODER;
    it.encoder_first  = first;
    it.encoder_second = second;
    return it;
  endfunction

  function automatic ccm_pkg::ccm_item_t key_event(input logic level);
    ccm_pkg::ccm_item_t it;
    it = random_event();
    it.opcode    = ccm_pkg::OP_KEY;
    it.key_level = level;
    return it;
  endfunction

  function automatic ccm_pkg::ccm_item_t preset_event(input int addr, input int value);
    ccm_pkg::ccm_item_t it;
    it = random_event();
    it.opcode       = ccm_pkg::OP_PRESET;
    it.preset_index = 5'(addr);
    it.preset_value = 8'(value);
    return it;
  endfunction

  // offer one word and hold it until the block takes it; returns at the
  // accepting edge so the next word can follow with no gap
  task automatic send_event(input ccm_pkg::ccm_item_t it);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      ev.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    ev.valid          <= 1'b1;
    ev.opcode         <= it.opcode;
    ev.control_index  <= it.control_index;
    ev.sample         <= it.sample;
    ev.encoder_first  <= it.encoder_first;
    ev.encoder_second <= it.encoder_second;
    ev.key_level      <= it.key_level;
    ev.preset_index   <= it.preset_index;
    ev.preset_value   <= it.preset_value;
    do @(posedge clk); while (!ev.ready);
  endtask

  // stop offering, wait for every predicted message, then let words that
  // give no message drain out of the two-stage pipe
  task automatic settle();
    ev.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic idx, input logic [12:0] value);
    settle();
    cf.valid <= 1'b1;
    cf.index <= idx;
    cf.data  <= value;
    do @(posedge clk); while (!cf.ready);
    cf.valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_event(random_event());
  endtask

  // message receiver: random stall bursts, plus one long hold-off on request
  initial begin
    msg.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        msg.ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        msg.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        msg.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst               <= 1'b1;
    ev.valid          <= 1'b0;
    ev.opcode         <= ccm_pkg::OP_ANALOG;
    ev.control_index  <= 4'd0;
    ev.sample         <= 10'd0;
    ev.encoder_first  <= ccm_pkg::ENC_IDLE;
    ev.encoder_second <= ccm_pkg::ENC_IDLE;
    ev.key_level      <= 1'b1;
    ev.preset_index   <= 5'd0;
    ev.preset_value   <= 8'd0;
    cf.valid          <= 1'b0;
    cf.index          <= ccm_pkg::REG_HYSTERESIS;
    cf.data           <= 13'd0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    squeeze = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    send_event(analog_event(0, 0));        // off the -1 start, inside threshold
    send_event(analog_event(0, 1023));     // full scale
    send_event(analog_event(5, 1023));     // knob with its invert bit set
    send_event(analog_event(12, 512));     // last knob
    send_event(analog_event(13, 1000));    // index past the last knob, ignored
    send_event(analog_event(15, 0));       // top index, ignored
    send_event(analog_event(0, 1016));     // change equal to threshold, no send
    send_event(analog_event(0, 1015));     // one past threshold
    send_event(encoder_event(ccm_pkg::ENC_DOWN, ccm_pkg::ENC_UP));   // reads disagree
    send_event(encoder_event(ccm_pkg::ENC_DOWN, ccm_pkg::ENC_DOWN)); // idle to down, zero
    send_event(encoder_event(ccm_pkg::ENC_IDLE, ccm_pkg::ENC_IDLE));
    send_event(encoder_event(ccm_pkg::ENC_UP, ccm_pkg::ENC_UP));     // idle to up, max
    send_event(encoder_event(2'd0, 2'd0));         // change not from idle
    send_event(encoder_event(ccm_pkg::ENC_IDLE, ccm_pkg::ENC_IDLE));
    send_event(encoder_event(2'd0, 2'd0));         // idle to both low, silent
    send_event(key_event(1'b1));           // first key word always sends
    send_event(key_event(1'b1));           // same level, silent
    send_event(key_event(1'b0));           // pressed
    send_event(preset_event(13, 9));       // encoder channel
    send_event(preset_event(29, 127));     // encoder controller
    send_event(preset_event(0, 200));      // value too large, ignored
    send_event(preset_event(16, 128));     // just too large, ignored
    send_event(preset_event(31, 127));
    send_event(encoder_event(ccm_pkg::ENC_IDLE, ccm_pkg::ENC_IDLE));
    send_event(encoder_event(ccm_pkg::ENC_DOWN, ccm_pkg::ENC_DOWN)); // new preset words

    // zero threshold, every knob inverted
    write_reg(ccm_pkg::REG_HYSTERESIS, 13'd0);
    write_reg(ccm_pkg::REG_INVERT, 13'h1FFF);
    run_random(300);

    // long receiver hold-off with a steady run of key toggles behind it,
    // so both pipe stages fill and the event side stalls
    tx_idle = 1'b0;
    squeeze = 1'b1;
    for (int i = 0; i < 40; i++) send_event(key_event(i[0]));
    tx_idle = 1'b1;

    // top threshold (upper data bits set too), no inversion
    write_reg(ccm_pkg::REG_HYSTERESIS, 13'h1FFF);
    write_reg(ccm_pkg::REG_INVERT, 13'h0000);
    run_random(200);

    write_reg(ccm_pkg::REG_HYSTERESIS, 13'($urandom_range(0, 63)));
    write_reg(ccm_pkg::REG_INVERT, 13'($urandom));
    run_random(300);

    // last stretch runs flat out on both sides
    write_reg(ccm_pkg::REG_HYSTERESIS, 13'($urandom_range(0, 15)));
    write_reg(ccm_pkg::REG_INVERT, 13'($urandom));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(300);

    settle();
    repeat (10) @(posedge clk);
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
